// ----- sv/gsbs_pkg.sv -----
// Package for the greedy separated best-subset unit.
// Holds store geometry, field widths, the stored entry type and the compare-unit result.
// No dependencies.
`default_nettype none

package gsbs_pkg;

  localparam int LIST_DEPTH = 64;
  localparam int IDX_W      = $clog2(LIST_DEPTH);
  localparam int CNT_W      = $clog2(LIST_DEPTH + 1);

  localparam int POS_W   = 20;
  localparam int SCORE_W = 32;
  localparam int TAG_W   = 16;
  localparam int SEP_W   = 10;

  typedef struct packed {
    logic [POS_W-1:0]          pos;
    logic signed [SCORE_W-1:0] score;
    logic [TAG_W-1:0]          tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Verdict of the shared compare unit for one stored entry.
  typedef struct packed {
    logic keep;    // entry stays alive after the window test
    logic better;  // entry beats the best seen so far in this pass
  } cmp_res_t;

endpackage

`default_nettype wire

// ----- sv/gsbs_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module gsbs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/gsbs_cmp.sv -----
// Shared compare unit: window suppression test and best-score compare for one entry.
// Depends on gsbs_pkg.
`default_nettype none

module gsbs_cmp (
  input  wire gsbs_pkg::entry_t               entry,
  input  wire logic                           alive,
  input  wire logic [gsbs_pkg::SEP_W-1:0]     sep,
  input  wire logic                           prev_vld,
  input  wire logic [gsbs_pkg::POS_W-1:0]     prev_pos,
  input  wire logic                           best_found,
  input  wire logic signed [gsbs_pkg::SCORE_W-1:0] best_score,
  output gsbs_pkg::cmp_res_t                  res
);

  logic [gsbs_pkg::POS_W:0] p_plus_sep;
  logic [gsbs_pkg::POS_W:0] prev_plus_sep;
  logic                     in_window;

  // prev - sep <= p <= prev + sep, kept non-negative by moving sep across
  assign p_plus_sep    = {1'b0, entry.pos} + (gsbs_pkg::POS_W+1)'(sep);
  assign prev_plus_sep = {1'b0, prev_pos} + (gsbs_pkg::POS_W+1)'(sep);
  assign in_window     = (p_plus_sep >= {1'b0, prev_pos}) &&
                         ({1'b0, entry.pos} <= prev_plus_sep);

  always_comb begin
    res.keep   = alive && !(prev_vld && in_window);
    res.better = res.keep && (!best_found || (entry.score > best_score));
  end

endmodule

`default_nettype wire

// ----- sv/greedy_separated_best_subset_unit.sv -----
// Greedy separated best-subset unit (1-D non-maximum suppression): top level.
// Depends on gsbs_pkg, gsbs_ram (candidate store) and gsbs_cmp (shared compare unit).
//
// Input channel (in_*): one candidate per transfer, one per cycle while loading, into a
// 64-entry store; extras are dropped and flagged on out_overflow. in_last_item closes the
// list and starts selection; in_ready stays low until the last result of the list has
// been loaded into the output register.
// Output channel (out_*): picks, highest score first (earliest loaded on a tie);
// out_last_result marks the final one. cfg_wr_en/cfg_wr_data set the separation; write
// only while idle.
// Separation zero: the list streams out in load order, one result per cycle while the
// receiver keeps up. Otherwise each pass over the store reads all N entries, drains
// the pipeline and ends in a push; K picks take K+1 passes, first result after two passes.
// A pick is held one pass to learn whether it is the last; each pass kills the window
// of the previous pick and searches the survivors. A stalled receiver holds the
// sequencer only when a result is ready and the output register is still full.
// Reset (rst_n low, synchronous) empties the list and sets separation to 0; store
// contents are not cleared, only entries of the current list are read.
`default_nettype none

module greedy_separated_best_subset_unit (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // configuration
  input  wire logic                                 cfg_wr_en,
  input  wire logic [gsbs_pkg::SEP_W-1:0]           cfg_wr_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_ready,
  input  wire logic [gsbs_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [gsbs_pkg::SCORE_W-1:0]  in_score,
  input  wire logic [gsbs_pkg::TAG_W-1:0]           in_tag,
  input  wire logic                                 in_last_item,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic [gsbs_pkg::POS_W-1:0]                out_sel_position,
  output logic signed [gsbs_pkg::SCORE_W-1:0]       out_sel_score,
  output logic [gsbs_pkg::TAG_W-1:0]                out_sel_tag,
  output logic                                      out_overflow,
  output logic                                      out_last_result
);

  localparam int IDX_W = gsbs_pkg::IDX_W;
  localparam int CNT_W = gsbs_pkg::CNT_W;

  typedef enum logic [1:0] {
    ST_LOAD,  // taking candidates
    ST_SCAN,  // one kill+search pass over the store
    ST_PUSH,  // hand the held pick to the output register
    ST_COPY   // separation zero: stream the store in load order
  } state_t;

  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [gsbs_pkg::LIST_DEPTH-1:0] alive_r, alive_nxt;
  logic [gsbs_pkg::SEP_W-1:0]   sep_r, sep_nxt;

  // read sequencing
  logic [CNT_W-1:0]             rd_idx_r, rd_idx_nxt;
  logic                         rd_vld_r, rd_vld_nxt;
  logic [IDX_W-1:0]             proc_idx_r, proc_idx_nxt;

  // best of the current pass
  logic                         best_found_r, best_found_nxt;
  gsbs_pkg::entry_t             best_r, best_nxt;

  // previous pick, held until we know whether it is the last
  logic                         pend_vld_r, pend_vld_nxt;
  gsbs_pkg::entry_t             pend_r, pend_nxt;

  // output register
  logic                         out_valid_r, out_valid_nxt;
  gsbs_pkg::entry_t             out_ent_r, out_ent_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic                         out_last_r, out_last_nxt;

  // store ports
  logic                         ram_wr_en;
  logic                         ram_rd_en;
  gsbs_pkg::entry_t             ram_wr_data;
  gsbs_pkg::entry_t             ram_rd_data;
  logic [gsbs_pkg::ENTRY_W-1:0] ram_rd_bits;

  gsbs_pkg::cmp_res_t           cmp_res;
  logic                         slot_free;
  logic                         more_to_read;
  logic                         can_issue;

  assign ram_wr_data.pos   = in_position;
  assign ram_wr_data.score = in_score;
  assign ram_wr_data.tag   = in_tag;
  assign ram_rd_data       = gsbs_pkg::entry_t'(ram_rd_bits);

  gsbs_ram #(
    .WIDTH (gsbs_pkg::ENTRY_W),
    .DEPTH (gsbs_pkg::LIST_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (cnt_r[IDX_W-1:0]),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (rd_idx_r[IDX_W-1:0]),
    .rd_data (ram_rd_bits)
  );

  gsbs_cmp u_cmp (
    .entry      (ram_rd_data),
    .alive      (alive_r[proc_idx_r]),
    .sep        (sep_r),
    .prev_vld   (pend_vld_r),
    .prev_pos   (pend_r.pos),
    .best_found (best_found_r),
    .best_score (best_r.score),
    .res        (cmp_res)
  );

  assign in_ready     = (state_r == ST_LOAD);
  assign slot_free    = !out_valid_r || out_ready;
  assign more_to_read = (rd_idx_r < cnt_r);
  assign can_issue    = !rd_vld_r || slot_free;

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    alive_nxt      = alive_r;
    sep_nxt        = sep_r;
    rd_idx_nxt     = rd_idx_r;
    rd_vld_nxt     = rd_vld_r;
    proc_idx_nxt   = proc_idx_r;
    best_found_nxt = best_found_r;
    best_nxt       = best_r;
    pend_vld_nxt   = pend_vld_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_ent_nxt    = out_ent_r;
    out_ovf_nxt    = out_ovf_r;
    out_last_nxt   = out_last_r;
    ram_wr_en      = 1'b0;
    ram_rd_en      = 1'b0;

    if (cfg_wr_en) begin
      sep_nxt = cfg_wr_data;
    end

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_LOAD: begin
        if (in_valid) begin
          if (cnt_r < CNT_W'(gsbs_pkg::LIST_DEPTH)) begin
            ram_wr_en                     = 1'b1;
            alive_nxt[cnt_r[IDX_W-1:0]]   = 1'b1;
            cnt_nxt                       = cnt_r + 1'b1;
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_item) begin
            rd_idx_nxt     = '0;
            rd_vld_nxt     = 1'b0;
            best_found_nxt = 1'b0;
            pend_vld_nxt   = 1'b0;
            state_nxt      = (sep_r == '0) ? ST_COPY : ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (rd_vld_r) begin
          alive_nxt[proc_idx_r] = cmp_res.keep;
          if (cmp_res.better) begin
            best_found_nxt = 1'b1;
            best_nxt       = ram_rd_data;
          end
        end
        if (more_to_read) begin
          ram_rd_en    = 1'b1;
          rd_idx_nxt   = rd_idx_r + 1'b1;
          rd_vld_nxt   = 1'b1;
          proc_idx_nxt = rd_idx_r[IDX_W-1:0];
        end else begin
          rd_vld_nxt = 1'b0;
          if (!rd_vld_r) begin
            state_nxt = ST_PUSH;
          end
        end
      end

      ST_PUSH: begin
        if (!pend_vld_r || slot_free) begin
          if (pend_vld_r) begin
            out_valid_nxt = 1'b1;
            out_ent_nxt   = pend_r;
            out_ovf_nxt   = ovf_r;
            out_last_nxt  = !best_found_r;
          end
          if (best_found_r) begin
            // new pick becomes the kill window of the next pass
            pend_vld_nxt   = 1'b1;
            pend_nxt       = best_r;
            best_found_nxt = 1'b0;
            rd_idx_nxt     = '0;
            state_nxt      = ST_SCAN;
          end else begin
            cnt_nxt      = '0;
            ovf_nxt      = 1'b0;
            alive_nxt    = '0;
            pend_vld_nxt = 1'b0;
            state_nxt    = ST_LOAD;
          end
        end
      end

      ST_COPY: begin
        // read data stays in the RAM output register until it is taken
        if (rd_vld_r && slot_free) begin
          out_valid_nxt = 1'b1;
          out_ent_nxt   = ram_rd_data;
          out_ovf_nxt   = ovf_r;
          out_last_nxt  = ((CNT_W'(proc_idx_r) + 1'b1) == cnt_r);
        end
        if (can_issue) begin
          if (more_to_read) begin
            ram_rd_en    = 1'b1;
            rd_idx_nxt   = rd_idx_r + 1'b1;
            rd_vld_nxt   = 1'b1;
            proc_idx_nxt = rd_idx_r[IDX_W-1:0];
          end else begin
            rd_vld_nxt = 1'b0;
          end
        end
        if (!rd_vld_r && !more_to_read) begin
          cnt_nxt   = '0;
          ovf_nxt   = 1'b0;
          alive_nxt = '0;
          state_nxt = ST_LOAD;
        end
      end

      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    // payload, no reset needed
    proc_idx_r <= proc_idx_nxt;
    best_r     <= best_nxt;
    pend_r     <= pend_nxt;
    out_ent_r  <= out_ent_nxt;
    out_ovf_r  <= out_ovf_nxt;
    out_last_r <= out_last_nxt;
    if (!rst_n) begin
      state_r      <= ST_LOAD;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      alive_r      <= '0;
      sep_r        <= '0;
      rd_idx_r     <= '0;
      rd_vld_r     <= 1'b0;
      best_found_r <= 1'b0;
      pend_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      alive_r      <= alive_nxt;
      sep_r        <= sep_nxt;
      rd_idx_r     <= rd_idx_nxt;
      rd_vld_r     <= rd_vld_nxt;
      best_found_r <= best_found_nxt;
      pend_vld_r   <= pend_vld_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_sel_position = out_ent_r.pos;
  assign out_sel_score    = out_ent_r.score;
  assign out_sel_tag      = out_ent_r.tag;
  assign out_overflow     = out_ovf_r;
  assign out_last_result  = out_last_r;

endmodule

`default_nettype wire

// ----- verif/gsbs_nms_checker.sv -----
// Checker for the greedy separated best-subset unit: watches the config port and both channels,
// predicts the selected candidates of each list and compares them with the output transfers.
// Depends on gsbs_pkg.

module gsbs_nms_checker (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 cfg_wr_en,
  input  wire logic [gsbs_pkg::SEP_W-1:0]           cfg_wr_data,
  input  wire logic                                 in_valid,
  input  wire logic                                 in_ready,
  input  wire logic [gsbs_pkg::POS_W-1:0]           in_position,
  input  wire logic signed [gsbs_pkg::SCORE_W-1:0]  in_score,
  input  wire logic [gsbs_pkg::TAG_W-1:0]           in_tag,
  input  wire logic                                 in_last_item,
  input  wire logic                                 out_valid,
  input  wire logic                                 out_ready,
  input  wire logic [gsbs_pkg::POS_W-1:0]           out_sel_position,
  input  wire logic signed [gsbs_pkg::SCORE_W-1:0]  out_sel_score,
  input  wire logic [gsbs_pkg::TAG_W-1:0]           out_sel_tag,
  input  wire logic                                 out_overflow,
  input  wire logic                                 out_last_result,
  output int                                        fail_count,
  output int                                        open_picks
);

  typedef struct packed {
    gsbs_pkg::entry_t cand;
    logic             ovf;
    logic             last;
  } pick_t;

  gsbs_pkg::entry_t                cand_mem [gsbs_pkg::LIST_DEPTH];
  logic [gsbs_pkg::LIST_DEPTH-1:0] live;
  int                              list_len = 0;
  logic                            dropped = 1'b0;
  logic [gsbs_pkg::SEP_W-1:0]      window = '0;
  pick_t                           pending_picks [$];
  int                              fails = 0;

  task automatic log_miss(input string msg);
    fails++;
    if (fails <= 10)
      $display("mismatch: %s", msg);
  endtask

  function automatic void add_pick(input int idx);
    pick_t p;
    p.cand = cand_mem[idx];
    p.ovf  = dropped;
    p.last = 1'b0;
    pending_picks.insert(pending_picks.size(), p);
  endfunction

  // Greedy suppression (plain load order at window zero) on the loaded list; clears it afterwards.
  function automatic void pick_survivors();
    int   i, best, lo, hi, first;
    logic found;
    first = pending_picks.size();
    if (window == '0) begin
      for (i = 0; i < list_len; i++)
        add_pick(i);
    end else begin
      do begin
        found = 1'b0;
        best  = 0;
        for (i = 0; i < list_len; i++) begin
          if (live[i] && (!found ||
              $signed(cand_mem[i].score) > $signed(cand_mem[best].score))) begin
            found = 1'b1;
            best  = i;
          end
        end
        if (found) begin
          add_pick(best);
          lo = int'(cand_mem[best].pos) - int'(window);
          hi = int'(cand_mem[best].pos) + int'(window);
          for (i = 0; i < list_len; i++)
            if (lo <= int'(cand_mem[i].pos) && int'(cand_mem[i].pos) <= hi)
              live[i] = 1'b0;
        end
      end while (found);
    end
    if (pending_picks.size() > first)
      pending_picks[pending_picks.size()-1].last = 1'b1;
    list_len = 0;
    dropped  = 1'b0;
    live     = '0;
  endfunction

  always @(posedge clk) begin : watch
    pick_t want, got;
    if (!rst_n) begin
      window   = '0;
      list_len = 0;
      dropped  = 1'b0;
      live     = '0;
      pending_picks.delete();
    end else begin
      if (cfg_wr_en)
        window = cfg_wr_data;
      if (in_valid && in_ready) begin
        if (list_len < gsbs_pkg::LIST_DEPTH) begin
          cand_mem[list_len] = {in_position, in_score, in_tag};
          live[list_len]     = 1'b1;
          list_len++;
        end else begin
          dropped = 1'b1;
        end
        if (in_last_item)
          pick_survivors();
      end
      if (out_valid && out_ready) begin
        got.cand.pos   = out_sel_position;
        got.cand.score = out_sel_score;
        got.cand.tag   = out_sel_tag;
        got.ovf        = out_overflow;
        got.last       = out_last_result;
        if (pending_picks.size() == 0) begin
          log_miss($sformatf("result with nothing expected: pos %h score %h tag %h",
                             got.cand.pos, got.cand.score, got.cand.tag));
        end else begin
          want = pending_picks.pop_front();
          if (got.cand.pos !== want.cand.pos)
            log_miss($sformatf("sel_position expected %h got %h",
                               want.cand.pos, got.cand.pos));
          if (got.cand.score !== want.cand.score)
            log_miss($sformatf("sel_score expected %h got %h",
                               want.cand.score, got.cand.score));
          if (got.cand.tag !== want.cand.tag)
            log_miss($sformatf("sel_tag expected %h got %h",
                               want.cand.tag, got.cand.tag));
          if (got.ovf !== want.ovf)
            log_miss($sformatf("overflow expected %b got %b (tag %h)",
                               want.ovf, got.ovf, want.cand.tag));
          if (got.last !== want.last)
            log_miss($sformatf("last_result expected %b got %b (tag %h)",
                               want.last, got.last, want.cand.tag));
        end
      end
    end
    fail_count <= fails;
    open_picks <= pending_picks.size();
  end

endmodule

// ----- verif/greedy_separated_best_subset_unit_tb.sv -----
// Testbench top for the greedy separated best-subset unit: clock, reset, stimulus, verdict.
// Depends on gsbs_pkg, greedy_separated_best_subset_unit and gsbs_nms_checker.

module greedy_separated_best_subset_unit_tb;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_TOGGLE} rx_mode_t;

  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 80;      // idle margin before a config write / verdict
  localparam int LIMIT_CYCLES  = 200000;  // watchdog, far above the slowest legal run

  logic                                 clk;
  logic                                 rst_n        = 1'b0;
  logic                                 cfg_wr_en    = 1'b0;
  logic [gsbs_pkg::SEP_W-1:0]           cfg_wr_data  = '0;
  logic                                 in_valid     = 1'b0;
  logic [gsbs_pkg::POS_W-1:0]           in_position  = '0;
  logic signed [gsbs_pkg::SCORE_W-1:0]  in_score     = '0;
  logic [gsbs_pkg::TAG_W-1:0]           in_tag       = '0;
  logic                                 in_last_item = 1'b0;
  logic                                 out_ready    = 1'b0;
  wire logic                            in_ready;
  wire logic                            out_valid;
  wire logic [gsbs_pkg::POS_W-1:0]      out_sel_position;
  wire logic signed [gsbs_pkg::SCORE_W-1:0] out_sel_score;
  wire logic [gsbs_pkg::TAG_W-1:0]      out_sel_tag;
  wire logic                            out_overflow;
  wire logic                            out_last_result;

  int   fail_count;
  int   open_picks;
  logic hold_toggle = 1'b0;  // flipped by the sender to request a long receiver hold
  int   burst_left  = 0;     // transfers left in the current sender burst

  greedy_separated_best_subset_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_position      (in_position),
    .in_score         (in_score),
    .in_tag           (in_tag),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sel_position (out_sel_position),
    .out_sel_score    (out_sel_score),
    .out_sel_tag      (out_sel_tag),
    .out_overflow     (out_overflow),
    .out_last_result  (out_last_result)
  );

  gsbs_nms_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_position      (in_position),
    .in_score         (in_score),
    .in_tag           (in_tag),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sel_position (out_sel_position),
    .out_sel_score    (out_sel_score),
    .out_sel_tag      (out_sel_tag),
    .out_overflow     (out_overflow),
    .out_last_result  (out_last_result),
    .fail_count       (fail_count),
    .open_picks       (open_picks)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: a hung handshake or a lost result ends here.
  initial begin
    #(2 * LIMIT_CYCLES);
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: segments of random stall patterns, plus one long hold-off on request
  // so the output register fills and the unit backs up into its input channel.
  initial begin : receiver
    rx_mode_t mode;
    int       seg_left;
    int       held;
    logic     hold_seen;
    mode      = RX_OPEN;
    seg_left  = 0;
    hold_seen = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_toggle != hold_seen) begin
        hold_seen = hold_toggle;
        out_ready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(posedge clk);
      end
      if (seg_left == 0) begin
        mode     = rx_mode_t'($urandom_range(0, 3));
        seg_left = $urandom_range(8, 64);
      end
      seg_left--;
      case (mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
        RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
        default:   out_ready <= ~out_ready;
      endcase
    end
  end

  // One candidate transfer. Called right after a rising edge, returns at the edge
  // where the transfer happened. Valid stays up between transfers of a burst;
  // it only drops when a gap opens before the next burst.
  task automatic offer(input logic [gsbs_pkg::POS_W-1:0] pos,
                       input logic [gsbs_pkg::SCORE_W-1:0] score,
                       input logic [gsbs_pkg::TAG_W-1:0] tag, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_position  <= pos;
    in_score     <= score;
    in_tag       <= tag;
    in_last_item <= last;
    do begin
      @(posedge clk);
    end while (!in_ready);
    burst_left--;
  endtask

  // Drop valid and wait until every expected pick has come back, then a margin.
  // The first edge lets the checker register picks of a list closed just now.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_picks != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_window(input logic [gsbs_pkg::SEP_W-1:0] sep);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= sep;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random list: most positions cluster around a random base so windows overlap,
  // scores lean on a few fixed values so ties show up.
  task automatic send_random_list(input int len);
    logic [gsbs_pkg::POS_W-1:0]   base, p;
    logic [gsbs_pkg::SCORE_W-1:0] s;
    int                           k;
    base = gsbs_pkg::POS_W'($urandom);
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 3) != 0)
        p = base + gsbs_pkg::POS_W'($urandom_range(0, 2200));
      else
        p = gsbs_pkg::POS_W'($urandom);
      case ($urandom_range(0, 7))
        0:       s = 32'h7FFF_FFFF;
        1:       s = 32'h8000_0000;
        2:       s = 32'h0001_0000;
        3:       s = 32'h0000_0000;
        default: s = $urandom;
      endcase
      offer(p, s, gsbs_pkg::TAG_W'($urandom), k == len - 1);
    end
  endtask

  initial begin : stimulus
    int ph, lists, k;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Separation still at its reset value of zero: list returns in load order,
    // including score and position extremes and a repeated position.
    offer(20'h00000, 32'h7FFF_FFFF, 16'h0000, 1'b0);
    offer(20'hFFFFF, 32'h8000_0000, 16'hFFFF, 1'b0);
    offer(20'h00005, 32'h0000_0000, 16'hA5A5, 1'b0);
    offer(20'h00005, 32'hFFFF_FFFF, 16'h5A5A, 1'b1);
    settle_idle();

    // Widest window. Single-entry list first, then windows that run past
    // both ends of the position range, with equal scores to force the
    // earliest-loaded tie break.
    set_window(10'h3FF);
    offer(20'h00000, 32'hFFFF_0000, 16'h0001, 1'b1);
    offer(20'hFFFFF, 32'h0001_0000, 16'h0010, 1'b0);
    offer(20'hFFC00, 32'h0001_0000, 16'h0011, 1'b0);  // exactly on the window edge
    offer(20'hFFBFF, 32'h0001_0000, 16'h0012, 1'b0);  // one past it
    offer(20'h003FF, 32'h0001_0000, 16'h0013, 1'b0);
    offer(20'h00400, 32'h0001_0000, 16'h0014, 1'b0);
    offer(20'h00000, 32'h7FFF_FFFF, 16'h0015, 1'b1);
    settle_idle();

    // Narrowest window: neighbors one apart, ties, a duplicate position.
    set_window(10'd1);
    offer(20'h00010, 32'h0000_0005, 16'h0020, 1'b0);
    offer(20'h00011, 32'h0000_0005, 16'h0021, 1'b0);
    offer(20'h00012, 32'h0000_0005, 16'h0022, 1'b0);
    offer(20'h00013, 32'h0000_0005, 16'h0023, 1'b0);
    offer(20'h00011, 32'hFFFF_FFFB, 16'h0024, 1'b1);

    // Random phases, each under its own separation; lists within a phase go
    // back to back without waiting for the results.
    for (ph = 0; ph < 7; ph++) begin
      settle_idle();
      case (ph)
        0:       set_window('0);
        1:       set_window(10'h3FF);
        2:       set_window(10'd1);
        default: set_window(gsbs_pkg::SEP_W'($urandom_range(2, 1022)));
      endcase
      // store overflow: two entries beyond depth, the last-marked one dropped
      if (ph == 3)
        send_random_list(gsbs_pkg::LIST_DEPTH + 2);
      lists = $urandom_range(2, 4);
      for (k = 0; k < lists; k++) begin
        send_random_list($urandom_range(1, 8));
        // long receiver hold while the next list is already being offered
        if (ph == 2 && k == 0)
          hold_toggle <= ~hold_toggle;
      end
    end

    settle_idle();
    if (fail_count == 0 && open_picks == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

endmodule
